// ===== src/vwq_pkg.sv =====
// Package for the video-memory write queue.
// Holds item codes, result codes, sequencer state types and fixed constants.
// No dependencies.
package vwq_pkg;

    // Item modes
    localparam logic [1:0] MODE_RESET = 2'd0;
    localparam logic [1:0] MODE_OPEN  = 2'd1;
    localparam logic [1:0] MODE_DATA  = 2'd2;
    localparam logic [1:0] MODE_FLUSH = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_OPEN_OK  = 2'd0;
    localparam logic [1:0] KIND_OPEN_REF = 2'd1;
    localparam logic [1:0] KIND_ADDR_WR  = 2'd2;
    localparam logic [1:0] KIND_DATA_WR  = 2'd3;

    // Header is address high, address low, length
    localparam int HEADER_BYTES = 3;

    // Cap on results of one flush
    localparam logic [5:0] MAX_RESULTS = 6'd62;

    // Main sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR_LO,
        ST_HDR_LEN,
        ST_REPLY,
        ST_FL_ISSUE,
        ST_FL_DATA,
        ST_FL_END
    } t_state;

    // Position within a record during flush replay
    typedef enum logic [1:0] {
        PH_HI,
        PH_LO,
        PH_LEN,
        PH_DATA
    } t_phase;

endpackage

// ===== src/vwq_if.sv =====
// Handshake interfaces for the write queue: item input and result output.
// Does not depend on vwq_pkg (none of its members are needed, widths are fixed).
interface vwq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] vram_addr;
    logic [7:0]  entry_length;
    logic [7:0]  data_byte;

    modport source (output valid, output mode, output vram_addr, output entry_length,
                    output data_byte, input ready);
    modport sink   (input valid, input mode, input vram_addr, input entry_length,
                    input data_byte, output ready);
endinterface

interface vwq_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

// ===== src/vwq_store.sv =====
// Byte store of the write queue: one write port, one read port, registered read.
// Standalone; contents are undefined until written.
module vwq_store #(
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [2**ADDR_W];
    logic [7:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/vram_write_queue.sv =====
// Video-memory write queue. Data and reset items are taken back to back.
// Open: accept, two header writes, reply into the output register;
// a refused open skips the header writes.
// Flush: accept, per byte an issue and a data step on the single store read port, an issue
// step per record end, final check and release; results drain through one output register.
// Reset: synchronous, active low; queue empty, no reservation; store undefined until written.
module vram_write_queue
    import vwq_pkg::*;
#(
    parameter int QUEUE_BYTES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vwq_in_if.sink     i_in,
    vwq_out_if.source  o_out
);

    localparam int AW = $clog2(QUEUE_BYTES);
    localparam int LW = $clog2(QUEUE_BYTES + 2);
    localparam int SW = 10;

    // Control state
    t_state        r_state, n_state;
    t_phase        r_phase, n_phase;
    logic [LW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_fptr, n_fptr;
    logic [7:0]    r_rsv, n_rsv;
    logic [LW-1:0] r_pos, n_pos;
    logic [5:0]    r_nres, n_nres;
    logic          r_hold_v, n_hold_v;
    logic          r_out_v;

    // Payload registers
    logic [AW-1:0] r_base, n_base;
    logic [7:0]    r_lo, n_lo;
    logic [7:0]    r_len, n_len;
    logic [1:0]    r_reply_kind, n_reply_kind;
    logic [7:0]    r_cnt, n_cnt;
    logic [1:0]    r_hold_kind, n_hold_kind;
    logic [7:0]    r_hold_val, n_hold_val;
    logic [1:0]    r_out_kind;
    logic [7:0]    r_out_val;
    logic          r_out_last;

    // Store access and output load
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic          w_re;
    logic [7:0]    w_rdata;
    logic          w_in_ready;
    logic          w_out_free;
    logic          w_out_load;
    logic [1:0]    w_ld_kind;
    logic [7:0]    w_ld_val;
    logic          w_ld_last;
    logic [SW-1:0] w_need;
    logic          w_refuse;

    vwq_store #(
        .ADDR_W (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_pos[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Room check for an open
    assign w_need   = SW'(r_fill) + SW'(HEADER_BYTES) + SW'(i_in.entry_length);
    assign w_refuse = (w_need >= SW'(QUEUE_BYTES));

    assign w_out_free = !r_out_v || o_out.ready;
    assign i_in.ready = w_in_ready;

    // Sequencer: next state, store access, output load
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_fill       = r_fill;
        n_fptr       = r_fptr;
        n_rsv        = r_rsv;
        n_pos        = r_pos;
        n_nres       = r_nres;
        n_hold_v     = r_hold_v;
        n_base       = r_base;
        n_lo         = r_lo;
        n_len        = r_len;
        n_reply_kind = r_reply_kind;
        n_cnt        = r_cnt;
        n_hold_kind  = r_hold_kind;
        n_hold_val   = r_hold_val;
        w_we         = 1'b0;
        w_waddr      = r_base;
        w_wdata      = r_len;
        w_re         = 1'b0;
        w_in_ready   = 1'b0;
        w_out_load   = 1'b0;
        w_ld_kind    = r_hold_kind;
        w_ld_val     = r_hold_val;
        w_ld_last    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    case (i_in.mode)
                        MODE_RESET: begin
                            n_fill = '0;
                            n_fptr = '0;
                            n_rsv  = '0;
                        end
                        MODE_OPEN: begin
                            if (w_refuse) begin
                                n_rsv        = '0;
                                n_reply_kind = KIND_OPEN_REF;
                                n_state      = ST_REPLY;
                            end else begin
                                // address high byte goes in now, the rest follows
                                w_we         = 1'b1;
                                w_waddr      = r_fill[AW-1:0];
                                w_wdata      = i_in.vram_addr[15:8];
                                n_base       = AW'(r_fill + LW'(1));
                                n_lo         = i_in.vram_addr[7:0];
                                n_len        = i_in.entry_length;
                                n_fptr       = AW'(r_fill + LW'(HEADER_BYTES));
                                n_rsv        = i_in.entry_length;
                                n_fill       = LW'(w_need);
                                n_reply_kind = KIND_OPEN_OK;
                                n_state      = ST_HDR_LO;
                            end
                        end
                        MODE_DATA: begin
                            if (r_rsv != 8'd0) begin
                                w_we    = 1'b1;
                                w_waddr = r_fptr;
                                w_wdata = i_in.data_byte;
                                n_fptr  = r_fptr + AW'(1);
                                n_rsv   = r_rsv - 8'd1;
                            end
                        end
                        MODE_FLUSH: begin
                            n_pos    = '0;
                            n_nres   = '0;
                            n_phase  = PH_HI;
                            n_hold_v = 1'b0;
                            n_state  = ST_FL_ISSUE;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_HDR_LO: begin
                w_we    = 1'b1;
                w_wdata = r_lo;
                n_base  = r_base + AW'(1);
                n_state = ST_HDR_LEN;
            end

            ST_HDR_LEN: begin
                w_we    = 1'b1;
                w_wdata = r_len;
                n_state = ST_REPLY;
            end

            ST_REPLY: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    w_ld_kind  = r_reply_kind;
                    w_ld_val   = 8'd0;
                    w_ld_last  = 1'b1;
                    n_state    = ST_IDLE;
                end
            end

            // Decide whether the walk goes on and issue the next read
            ST_FL_ISSUE: begin
                case (r_phase)
                    PH_HI: begin
                        if ((r_pos < r_fill) && (r_nres < MAX_RESULTS)) begin
                            w_re    = 1'b1;
                            n_state = ST_FL_DATA;
                        end else begin
                            n_state = ST_FL_END;
                        end
                    end
                    PH_LO: begin
                        if (r_nres < MAX_RESULTS) begin
                            w_re    = 1'b1;
                            n_state = ST_FL_DATA;
                        end else begin
                            n_state = ST_FL_END;
                        end
                    end
                    PH_LEN: begin
                        w_re    = 1'b1;
                        n_state = ST_FL_DATA;
                    end
                    PH_DATA: begin
                        if ((r_cnt != 8'd0) && (r_pos < r_fill) &&
                            (r_nres < MAX_RESULTS)) begin
                            w_re    = 1'b1;
                            n_state = ST_FL_DATA;
                        end else begin
                            n_phase = PH_HI;
                        end
                    end
                    default: begin
                        n_state = ST_FL_END;
                    end
                endcase
            end

            // Read data is back; the previous result is held until the next
            // one shows that it was not the last
            ST_FL_DATA: begin
                if (r_phase == PH_LEN) begin
                    n_cnt   = w_rdata;
                    n_phase = PH_DATA;
                    n_pos   = r_pos + LW'(1);
                    n_state = ST_FL_ISSUE;
                end else if (!r_hold_v || w_out_free) begin
                    w_out_load  = r_hold_v;
                    n_hold_v    = 1'b1;
                    n_hold_kind = (r_phase == PH_DATA) ? KIND_DATA_WR : KIND_ADDR_WR;
                    n_hold_val  = w_rdata;
                    n_nres      = r_nres + 6'd1;
                    n_pos       = r_pos + LW'(1);
                    n_state     = ST_FL_ISSUE;
                    case (r_phase)
                        PH_HI:   n_phase = PH_LO;
                        PH_LO:   n_phase = PH_LEN;
                        PH_DATA: n_cnt   = r_cnt - 8'd1;
                        default: n_phase = PH_HI;
                    endcase
                end
            end

            // Release the final result with last set, then empty the queue
            ST_FL_END: begin
                if (!r_hold_v || w_out_free) begin
                    w_out_load = r_hold_v;
                    w_ld_last  = 1'b1;
                    n_hold_v   = 1'b0;
                    n_fill     = '0;
                    n_fptr     = '0;
                    n_rsv      = '0;
                    n_state    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_HI;
            r_fill   <= '0;
            r_fptr   <= '0;
            r_rsv    <= '0;
            r_pos    <= '0;
            r_nres   <= '0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_fill   <= n_fill;
            r_fptr   <= n_fptr;
            r_rsv    <= n_rsv;
            r_pos    <= n_pos;
            r_nres   <= n_nres;
            r_hold_v <= n_hold_v;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_base       <= n_base;
        r_lo         <= n_lo;
        r_len        <= n_len;
        r_reply_kind <= n_reply_kind;
        r_cnt        <= n_cnt;
        r_hold_kind  <= n_hold_kind;
        r_hold_val   <= n_hold_val;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_load) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_kind <= w_ld_kind;
            r_out_val  <= w_ld_val;
            r_out_last <= w_ld_last;
        end
    end

    assign o_out.valid = r_out_v;
    assign o_out.kind  = r_out_kind;
    assign o_out.value = r_out_val;
    assign o_out.last  = r_out_last;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for vram_write_queue: directed and random item streams.
// Expected register writes are predicted in a scoreboard class and compared in order.
// Depends on vwq_pkg, vwq_if and the vram_write_queue RTL.
module tb_top;
    import vwq_pkg::*;

    localparam int QUEUE_BYTES    = 64;
    localparam int STORE_DEPTH    = 64;
    // Longest record that still fits in an empty queue
    localparam int MAX_RECORD_LEN = QUEUE_BYTES - HEADER_BYTES - 1;
    localparam int RANDOM_ITEMS   = 40;
    localparam int SETTLE_CYCLES  = 200;
    localparam int DRAIN_GUARD    = 50000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } reg_write_t;

    // Shadow copy of the queue plus the register writes still owed by the block
    class write_record_board;
        logic [7:0] store [STORE_DEPTH];
        logic [6:0] fill_level;
        logic [5:0] fill_ptr;
        logic [7:0] reserved;
        reg_write_t expected_writes [$];
        int         mismatches;

        function new();
            foreach (store[k]) store[k] = 8'h00;
            fill_level = '0;
            fill_ptr   = '0;
            reserved   = '0;
            mismatches = 0;
        endfunction

        function void clear_queue();
            fill_level = '0;
            fill_ptr   = '0;
            reserved   = '0;
        endfunction

        // Update the shadow state for one accepted transaction, queue its writes
        function void accept_item(logic [1:0] mode, logic [15:0] addr,
                                  logic [7:0] len, logic [7:0] dat);
            int         pos;
            logic [7:0] remaining;
            reg_write_t replay [$];
            reg_write_t w;
            case (mode)
                MODE_RESET: begin
                    clear_queue();
                end
                MODE_OPEN: begin
                    pos = int'(fill_level);
                    if (pos + HEADER_BYTES + int'(len) >= QUEUE_BYTES) begin
                        reserved = '0;
                        expected_writes.push_back('{kind: KIND_OPEN_REF, value: 8'h00,
                                                    last: 1'b1});
                    end else begin
                        store[pos % STORE_DEPTH]       = addr[15:8];
                        store[(pos + 1) % STORE_DEPTH] = addr[7:0];
                        store[(pos + 2) % STORE_DEPTH] = len;
                        fill_ptr   = 6'((pos + HEADER_BYTES) % STORE_DEPTH);
                        reserved   = len;
                        fill_level = 7'(pos + HEADER_BYTES + int'(len));
                        expected_writes.push_back('{kind: KIND_OPEN_OK, value: 8'h00,
                                                    last: 1'b1});
                    end
                end
                MODE_DATA: begin
                    // bytes with no open reservation are dropped
                    if (reserved != 8'd0) begin
                        store[fill_ptr] = dat;
                        fill_ptr = fill_ptr + 6'd1;
                        reserved = reserved - 8'd1;
                    end
                end
                default: begin
                    // flush: replay each record as header writes then data writes
                    pos = 0;
                    while (pos < int'(fill_level) && replay.size() < int'(MAX_RESULTS)) begin
                        replay.push_back('{kind: KIND_ADDR_WR,
                                           value: store[pos % STORE_DEPTH], last: 1'b0});
                        if (replay.size() >= int'(MAX_RESULTS)) break;
                        replay.push_back('{kind: KIND_ADDR_WR,
                                           value: store[(pos + 1) % STORE_DEPTH], last: 1'b0});
                        remaining = store[(pos + 2) % STORE_DEPTH];
                        pos += HEADER_BYTES;
                        while (remaining != 8'd0 && pos < int'(fill_level)
                               && replay.size() < int'(MAX_RESULTS)) begin
                            replay.push_back('{kind: KIND_DATA_WR,
                                               value: store[pos % STORE_DEPTH], last: 1'b0});
                            pos++;
                            remaining = remaining - 8'd1;
                        end
                    end
                    clear_queue();
                    foreach (replay[k]) begin
                        w = replay[k];
                        w.last = (k == replay.size() - 1);
                        expected_writes.push_back(w);
                    end
                end
            endcase
        endfunction

        task flag_mismatch(string what);
            mismatches++;
            $display("MISMATCH @%0t: %s", $time, what);
        endtask

        // Compare one accepted output transaction with the oldest expected write
        task match_write(logic [1:0] kind, logic [7:0] value, logic last);
            reg_write_t w;
            if (expected_writes.size() == 0) begin
                flag_mismatch($sformatf("unexpected write kind=%0d value=%02h last=%0b",
                                        kind, value, last));
            end else begin
                w = expected_writes.pop_front();
                if (kind !== w.kind)
                    flag_mismatch($sformatf("kind %0d, expected %0d", kind, w.kind));
                if (value !== w.value)
                    flag_mismatch($sformatf("value %02h, expected %02h", value, w.value));
                if (last !== w.last)
                    flag_mismatch($sformatf("last %0b, expected %0b", last, w.last));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    vwq_in_if  item_if ();
    vwq_out_if write_if ();

    write_record_board board;
    int items_sent  = 0;
    int send_streak = 0;
    int take_streak = 0;

    vram_write_queue #(
        .QUEUE_BYTES(QUEUE_BYTES)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (item_if),
        .o_out  (write_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Idle cycles before the next transaction; occasional stretches with none
    function automatic int idle_cycles(inout int streak);
        if (streak > 0) begin
            streak--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            streak = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    // Present one item and hold it until the block takes it
    task automatic send_item(logic [1:0] mode, logic [15:0] addr,
                             logic [7:0] len, logic [7:0] dat);
        int gap;
        if (mode != MODE_DATA || board.reserved != 8'd0) items_sent++;
        gap = idle_cycles(send_streak);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid        <= 1'b1;
        item_if.mode         <= mode;
        item_if.vram_addr    <= addr;
        item_if.entry_length <= len;
        item_if.data_byte    <= dat;
        do @(posedge i_clk); while (!(item_if.valid && item_if.ready));
        board.accept_item(mode, addr, len, dat);
    endtask

    task automatic open_and_fill(logic [15:0] addr, logic [7:0] len, int count);
        send_item(MODE_OPEN, addr, len, 8'($urandom));
        repeat (count) send_item(MODE_DATA, 16'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Hold off new items until every expected write has come out
    task automatic drain_writes();
        int guard;
        guard = 0;
        item_if.valid <= 1'b0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (board.expected_writes.size() != 0 && guard < DRAIN_GUARD);
    endtask

    // Stimulus
    initial begin
        int         target;
        int         room;
        int         pick;
        logic [7:0] len;

        board = new();
        i_rst_n              <= 1'b0;
        item_if.valid        <= 1'b0;
        item_if.mode         <= MODE_RESET;
        item_if.vram_addr    <= '0;
        item_if.entry_length <= '0;
        item_if.data_byte    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty queue, stray bytes, refusals, zero-length record
        send_item(MODE_FLUSH, 16'h0000, 8'h00, 8'h00);
        send_item(MODE_DATA,  16'h0000, 8'h00, 8'hFF);
        send_item(MODE_OPEN,  16'hFFFF, 8'hFF, 8'h00);
        send_item(MODE_DATA,  16'hFFFF, 8'hFF, 8'h00);
        send_item(MODE_OPEN,  16'h0000, 8'h00, 8'h00);
        // exactly reaches the queue size: refused
        send_item(MODE_OPEN,  16'hA55A, 8'd58, 8'h00);
        send_item(MODE_OPEN,  16'h1234, 8'd2,  8'h00);
        send_item(MODE_DATA,  16'h0000, 8'h00, 8'hFF);
        send_item(MODE_DATA,  16'h0000, 8'h00, 8'h00);
        send_item(MODE_FLUSH, 16'h0000, 8'h00, 8'h00);
        // reset item drops a half-filled record
        send_item(MODE_OPEN,  16'h00FF, 8'd4,  8'h00);
        send_item(MODE_DATA,  16'h0000, 8'h00, 8'h5A);
        send_item(MODE_RESET, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(MODE_FLUSH, 16'h0000, 8'h00, 8'h00);

        // Largest record that fits, fully written, gives the longest replay.
        // It also writes every store entry a later flush can read.
        open_and_fill(16'($urandom), 8'(MAX_RECORD_LEN), MAX_RECORD_LEN);
        send_item(MODE_FLUSH, 16'h0000, 8'h00, 8'h00);
        drain_writes();

        // Abandoned reservation replays stale bytes; dropped byte; refusal
        send_item(MODE_OPEN,  16'hFF00, 8'd3,  8'h00);
        send_item(MODE_DATA,  16'h0000, 8'h00, 8'hC3);
        send_item(MODE_OPEN,  16'h8001, 8'd2,  8'h00);
        send_item(MODE_DATA,  16'h0000, 8'h00, 8'h11);
        send_item(MODE_DATA,  16'h0000, 8'h00, 8'h22);
        send_item(MODE_DATA,  16'h0000, 8'h00, 8'h33);
        send_item(MODE_OPEN,  16'h7FFE, 8'd50, 8'h00);
        send_item(MODE_FLUSH, 16'h0000, 8'h00, 8'h00);

        // Random part: mostly complete records with random content
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            room = MAX_RECORD_LEN - int'(board.fill_level);
            pick = $urandom_range(0, 99);
            if (pick < 55 && room >= 0) begin
                if ($urandom_range(0, 5) == 0)
                    len = 8'($urandom_range(0, room));
                else
                    len = 8'($urandom_range(0, (room < 10) ? room : 10));
                open_and_fill(16'($urandom), len, int'(len));
                if ($urandom_range(0, 2) == 0)
                    send_item(MODE_FLUSH, 16'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 70 || room < 0) begin
                send_item(MODE_FLUSH, 16'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 82) begin
                // partly filled record, or one byte too long to fit
                len = 8'($urandom_range(0, room + 1));
                open_and_fill(16'($urandom), len, $urandom_range(0, int'(len)));
            end else begin
                send_item(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
                          8'($urandom));
            end
            if ($urandom_range(0, 14) == 0) drain_writes();
        end

        drain_writes();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.expected_writes.size() != 0)
            board.flag_mismatch($sformatf("%0d expected writes never came",
                                          board.expected_writes.size()));
        if (board.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Result side: random stalls, check every accepted write
    initial begin
        int stall;
        write_if.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = idle_cycles(take_streak);
            if (stall > 0) begin
                write_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            write_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(write_if.valid && write_if.ready));
            board.match_write(write_if.kind, write_if.value, write_if.last);
        end
    end

    // Run limit
    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/vwq_pkg.sv
src/vwq_if.sv
src/vwq_store.sv
src/vram_write_queue.sv
tb/tb_top.sv
